/* design/msbpk_pkg.sv */
// Shared types and constants for the MSB-first bit packer.
package msbpk_pkg;

    localparam int BYTE_BITS    = 8;
    localparam int HELD_W       = BYTE_BITS - 1;
    localparam int CNT_W        = 5;
    localparam int VAL_W        = 31;
    localparam int MAX_FIELD_DEF = 31;
    localparam int ACC_W        = HELD_W + VAL_W;
    localparam int TOT_W        = $clog2(ACC_W + 1);
    localparam int HCNT_W       = $clog2(BYTE_BITS);
    localparam int S_TDATA_W    = ((CNT_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = BYTE_BITS;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic load;
        logic emit;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic ge_byte;
        logic last_byte;
        logic out_free;
    } dp_status_t;

endpackage

/* design/msbpk_ctrl.sv */
// Controller state machine that sequences load, byte emission and wrap-up.
module msbpk_ctrl
    import msbpk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!status.ge_byte)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free && status.last_byte)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RUN:
            begin
                if (!status.ge_byte)
                begin
                    cmd.finish = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.finish = status.last_byte;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* design/msbpk_datapath.sv */
// Datapath: bit accumulator, leftover bits and the output byte register.
module msbpk_datapath
    import msbpk_pkg::*;
#(
    parameter int MAX_FIELD_BITS = MAX_FIELD_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CNT_W-1:0]     bit_count,
    input  logic [VAL_W-1:0]     bit_value,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_BITS-1:0] out_byte,
    output logic                 last_of_run
);

    localparam int SAT_BITS = (MAX_FIELD_BITS > VAL_W) ? VAL_W : MAX_FIELD_BITS;

    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [HELD_W-1:0]    held_bits_reg, held_bits_next;
    logic [HCNT_W-1:0]    held_count_reg, held_count_next;
    logic [BYTE_BITS-1:0] out_byte_reg, out_byte_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]     n_sat;
    logic [VAL_W-1:0]     val_mask;
    logic [TOT_W-1:0]     total_less;
    logic [TOT_W-1:0]     total_after;
    logic [ACC_W-1:0]     acc_shifted;
    logic [HELD_W-1:0]    held_mask;

    always_comb
    begin
        n_sat = (bit_count > CNT_W'(SAT_BITS)) ? CNT_W'(SAT_BITS) : bit_count;
        val_mask = (VAL_W'(1) << n_sat) - VAL_W'(1);
        total_less = total_reg - TOT_W'(BYTE_BITS);
        acc_shifted = acc_reg >> total_less;
        total_after = cmd.emit ? total_less : total_reg;
        held_mask = (HELD_W'(1) << total_after[HCNT_W-1:0]) - HELD_W'(1);

        status.ge_byte   = (total_reg >= TOT_W'(BYTE_BITS));
        status.last_byte = (total_reg < TOT_W'(2 * BYTE_BITS));
        status.out_free  = !out_valid_reg || out_ready;

        acc_next        = acc_reg;
        total_next      = total_reg;
        held_bits_next  = held_bits_reg;
        held_count_next = held_count_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            acc_next = (ACC_W'(held_bits_reg) << n_sat) | ACC_W'(bit_value & val_mask);
            total_next = TOT_W'(held_count_reg) + TOT_W'(n_sat);
        end
        if (cmd.emit)
        begin
            total_next     = total_less;
            out_byte_next  = acc_shifted[BYTE_BITS-1:0];
            out_last_next  = status.last_byte;
            out_valid_next = 1'b1;
        end
        if (cmd.finish)
        begin
            held_bits_next  = acc_reg[HELD_W-1:0] & held_mask;
            held_count_next = total_after[HCNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bits_reg  <= '0;
            held_count_reg <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_bits_reg  <= held_bits_next;
            held_count_reg <= held_count_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

endmodule

/* design/msb_first_bit_packer_core.sv */
// Top level of the MSB-first variable-length bit packer.
// The slave stream takes one field per transfer: a bit count of 0 to 31 and a
// right-aligned value whose bits above the count are ignored. Counts above
// MAX_FIELD_BITS are saturated. The field is appended, most significant bit
// first, after the leftover bits of earlier fields.
// The master stream gives one completed byte per transfer, earliest bit in
// the most significant position, with tlast on the final byte of the field.
// A field that completes no byte gives no transfer; a partial byte stays held.
// A field is taken in the idle state, then each byte leaves through the output
// register at one per cycle while the receiver does not stall; the byte loop
// sets this rate. The first byte reaches the master side through the
// accumulator register and then the output byte register.
// When the receiver stalls, the byte register holds its transfer and the
// emission loop waits; no new field is taken until the current one is done.
// Reset clears the leftover bits and the output valid.
module msb_first_bit_packer_core
    import msbpk_pkg::*;
#(
    parameter int MAX_FIELD_BITS = MAX_FIELD_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // bit_count[4:0], bit_value[35:5], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // out_byte[7:0]
    output logic                 m_tlast
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    msbpk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    msbpk_datapath #(
        .MAX_FIELD_BITS (MAX_FIELD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .bit_count   (s_tdata[CNT_W-1:0]),
        .bit_value   (s_tdata[CNT_W+VAL_W-1:CNT_W]),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .last_of_run (m_tlast)
    );

endmodule
